>>> hw/rtl/mlfq_pkg.sv
// Shared types, constants and helper functions for the feedback queue scheduler.
package mlfq_pkg;
    localparam int NUM_LEVELS = 12;
    localparam int MAX_PROCS  = 64;
    localparam int PID_W      = 6;
    localparam int LVL_W      = 4;
    localparam int LINK_W     = 7;
    localparam int TBL_W      = 48;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] FUNC_ENQ  = 2'd0;
    localparam logic [1:0] FUNC_SET  = 2'd1;
    localparam logic [1:0] FUNC_PICK = 2'd2;
    localparam logic [1:0] FUNC_RET  = 2'd3;

    localparam logic [1:0] ST_SLEEP = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_OTHER = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NONE   = 2'd1;
    localparam logic [1:0] STAT_BAD    = 2'd2;
    localparam logic [1:0] STAT_QUEUED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP   = 2'd2;

    localparam logic [TBL_W-1:0] QUANTUM_RST = 48'd18765287024264;
    localparam logic [TBL_W-1:0] TIMEOUT_RST = 48'd206413245849856;
    localparam logic [TBL_W-1:0] SLEEP_RST   = 48'd206413819696452;

    localparam logic [LINK_W-1:0] NIL = 7'h40;
    localparam logic [LVL_W-1:0] TOP_LEVEL = 4'd11;

    typedef struct packed {
        logic [1:0]       func;
        logic [PID_W-1:0] pid;
        logic [LVL_W-1:0] level;
        logic [1:0]       new_state;
    } in_item_t;

    typedef struct packed {
        logic [PID_W-1:0] chosen_pid;
        logic [LVL_W-1:0] chosen_level;
        logic [3:0]       quantum;
        logic [1:0]       status;
    } out_item_t;

    // Command after decode: function, pid, saturated level, normalized state.
    typedef struct packed {
        logic [1:0]       func;
        logic [PID_W-1:0] pid;
        logic [LVL_W-1:0] level;
        logic [1:0]       new_state;
    } cmd_t;

    function automatic logic [3:0] nibble(input logic [TBL_W-1:0] tbl,
                                          input logic [LVL_W-1:0] lv);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 12; i++)
            if (lv == LVL_W'(i)) r = tbl[4*i +: 4];
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] sat_level(input logic [3:0] v);
        return (v > TOP_LEVEL) ? TOP_LEVEL : v;
    endfunction
endpackage

>>> hw/rtl/mlfq_front.sv
// Front end: accepts items, normalizes fields and queues commands for the engine.
module mlfq_front import mlfq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_take
);
    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       dec;

    always_comb
    begin
        dec.func      = in_item.func;
        dec.pid       = in_item.pid;
        dec.level     = sat_level(in_item.level);
        dec.new_state = (in_item.new_state > ST_OTHER) ? ST_OTHER : in_item.new_state;
    end

    assign full      = cnt_reg == 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full) q_reg[wp_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full) wp_reg <= !wp_reg;
            if (cmd_take) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(cmd_take);
        end
    end
endmodule

>>> hw/rtl/mlfq_engine.sv
// Back end: linked-list queue state, the multi-cycle command sequencer and its generic RAM.
module mlfq_engine import mlfq_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_take,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [TBL_W-1:0]     cfg_data,
    input  logic                 pop,
    output logic                 empty,
    output out_item_t            out_item
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_INFO = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;

    typedef struct packed {
        logic             queued;
        logic [1:0]       state;
        logic [LVL_W-1:0] level;
    } pinfo_t;

    logic [TBL_W-1:0]  qt_reg, tt_reg, st_reg;
    logic [LINK_W-1:0] head_reg  [NUM_LEVELS];
    logic [LINK_W-1:0] tail_reg  [NUM_LEVELS];
    logic [LINK_W-1:0] head_next [NUM_LEVELS];
    logic [LINK_W-1:0] tail_next [NUM_LEVELS];

    logic [2:0]       fsm_reg, fsm_next;
    logic [LVL_W-1:0] lv_reg, lv_next;
    logic [PID_W-1:0] cur_reg, cur_next;
    logic [PID_W-1:0] clr_reg, clr_next;
    logic [PID_W-1:0] link_reg, link_next;
    cmd_t             op_reg, op_next;
    out_item_t        res_reg, res_next;
    logic             res_full_reg;
    logic             res_set;

    logic [PID_W-1:0]  rd_addr;
    logic              info_we;
    logic [PID_W-1:0]  info_waddr;
    pinfo_t            info_wdata, info_rd;
    logic              nxt_we;
    logic [PID_W-1:0]  nxt_waddr;
    logic [LINK_W-1:0] nxt_wdata, nxt_rd;
    logic              prv_we;
    logic [PID_W-1:0]  prv_waddr;
    logic [LINK_W-1:0] prv_wdata, prv_rd;

    logic             do_append;
    logic [LVL_W-1:0] alv;

    assign empty    = !res_full_reg;
    assign out_item = res_reg;

    mlfq_ram #(.WIDTH($bits(pinfo_t)), .DEPTH(MAX_PROCS)) u_info (
        .clk, .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(rd_addr), .rdata(info_rd)
    );

    mlfq_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PROCS)) u_next (
        .clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(rd_addr), .rdata(nxt_rd)
    );

    mlfq_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PROCS)) u_prev (
        .clk, .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(rd_addr), .rdata(prv_rd)
    );

    // Enqueue and a return that leaves the process sleeping or runnable append to a level.
    always_comb
    begin
        do_append = (op_reg.func == FUNC_ENQ)
                    || (op_reg.func == FUNC_RET && op_reg.new_state != ST_OTHER);
        alv = op_reg.level;
        if (op_reg.func == FUNC_RET)
            alv = sat_level(nibble((op_reg.new_state == ST_RUN) ? tt_reg : st_reg,
                                   info_rd.level));
    end

    always_comb
    begin
        fsm_next   = fsm_reg;
        lv_next    = lv_reg;
        cur_next   = cur_reg;
        clr_next   = clr_reg;
        link_next  = link_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        res_set    = 1'b0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cmd_take   = 1'b0;
        rd_addr    = cmd.pid;
        info_we    = 1'b0;
        info_waddr = op_reg.pid;
        info_wdata = info_rd;
        nxt_we     = 1'b0;
        nxt_waddr  = op_reg.pid;
        nxt_wdata  = NIL;
        prv_we     = 1'b0;
        prv_waddr  = op_reg.pid;
        prv_wdata  = NIL;
        unique case (fsm_reg)
            S_CLR:
            begin
                info_we    = 1'b1;
                info_waddr = clr_reg;
                info_wdata = '{queued: 1'b0, state: ST_OTHER, level: '0};
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == PID_W'(MAX_PROCS - 1)) fsm_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd_take = cmd_valid && (!res_full_reg || pop);
                if (cmd_take)
                begin
                    op_next = cmd;
                    if (cmd.func == FUNC_PICK)
                    begin
                        lv_next  = TOP_LEVEL;
                        fsm_next = S_SCAN;
                    end
                    else fsm_next = S_INFO;
                end
            end
            S_INFO:
            begin
                res_next = '0;
                res_set  = 1'b1;
                fsm_next = S_IDLE;
                info_we  = 1'b1;
                if (op_reg.func != FUNC_ENQ) info_wdata.state = op_reg.new_state;
                if (do_append)
                begin
                    if (info_rd.queued) res_next.status = STAT_QUEUED;
                    else
                    begin
                        info_wdata.queued = 1'b1;
                        prv_we         = 1'b1;
                        prv_wdata      = tail_reg[alv];
                        nxt_we         = 1'b1;
                        tail_next[alv] = {1'b0, op_reg.pid};
                        if (tail_reg[alv][PID_W]) head_next[alv] = {1'b0, op_reg.pid};
                        else
                        begin
                            // The old tail's forward link is written in the next cycle.
                            link_next = tail_reg[alv][PID_W-1:0];
                            fsm_next  = S_LINK;
                        end
                    end
                end
            end
            S_LINK:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = link_reg;
                nxt_wdata = {1'b0, op_reg.pid};
                fsm_next  = S_IDLE;
            end
            S_SCAN:
            begin
                rd_addr  = head_reg[lv_reg][PID_W-1:0];
                cur_next = head_reg[lv_reg][PID_W-1:0];
                if (!head_reg[lv_reg][PID_W]) fsm_next = S_WALK;
                else if (lv_reg == '0)
                begin
                    res_next        = '0;
                    res_next.status = STAT_NONE;
                    res_set         = 1'b1;
                    fsm_next        = S_IDLE;
                end
                else lv_next = lv_reg - 1'b1;
            end
            S_WALK:
            begin
                rd_addr = nxt_rd[PID_W-1:0];
                if (info_rd.state == ST_RUN)
                begin
                    if (prv_rd[PID_W]) head_next[lv_reg] = nxt_rd;
                    else
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = prv_rd[PID_W-1:0];
                        nxt_wdata = nxt_rd;
                    end
                    if (nxt_rd[PID_W]) tail_next[lv_reg] = prv_rd;
                    else
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = nxt_rd[PID_W-1:0];
                        prv_wdata = prv_rd;
                    end
                    info_we    = 1'b1;
                    info_waddr = cur_reg;
                    info_wdata = '{queued: 1'b0, state: ST_OTHER, level: lv_reg};
                    res_next   = '{chosen_pid: cur_reg, chosen_level: lv_reg,
                                   quantum: nibble(qt_reg, lv_reg), status: STAT_OK};
                    res_set    = 1'b1;
                    fsm_next   = S_IDLE;
                end
                else if (info_rd.state != ST_SLEEP)
                begin
                    res_next = '{chosen_pid: cur_reg, chosen_level: lv_reg,
                                 quantum: 4'd0, status: STAT_BAD};
                    res_set  = 1'b1;
                    fsm_next = S_IDLE;
                end
                else if (!nxt_rd[PID_W]) cur_next = nxt_rd[PID_W-1:0];
                else if (lv_reg == '0)
                begin
                    res_next        = '0;
                    res_next.status = STAT_NONE;
                    res_set         = 1'b1;
                    fsm_next        = S_IDLE;
                end
                else
                begin
                    lv_next  = lv_reg - 1'b1;
                    fsm_next = S_SCAN;
                end
            end
            default: fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qt_reg <= QUANTUM_RST;
            tt_reg <= TIMEOUT_RST;
            st_reg <= SLEEP_RST;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            fsm_reg      <= S_CLR;
            lv_reg       <= '0;
            cur_reg      <= '0;
            clr_reg      <= '0;
            link_reg     <= '0;
            op_reg       <= '0;
            res_reg      <= '0;
            res_full_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_QUANTUM: qt_reg <= cfg_data;
                    CFG_TIMEOUT: tt_reg <= cfg_data;
                    CFG_SLEEP:   st_reg <= cfg_data;
                    default: ;
                endcase
            end
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
            fsm_reg      <= fsm_next;
            lv_reg       <= lv_next;
            cur_reg      <= cur_next;
            clr_reg      <= clr_next;
            link_reg     <= link_next;
            op_reg       <= op_next;
            res_reg      <= res_next;
            res_full_reg <= res_set || (res_full_reg && !pop);
        end
    end
endmodule

// Generic single-port-write RAM with a registered read.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end
endmodule

>>> hw/rtl/multilevel_feedback_queue_scheduler_core.sv
// Multilevel feedback queue scheduler: a command queue in front of the list engine.
// Enqueue, set state and return: command queue, info state, then the registered result.
// Pick: scans levels from the top down and examines each queued entry in list order.
// One item runs at a time (a non-empty level's append adds the link state); two more can wait.
// Reset is asynchronous: levels empty, tables at defaults; a clear pass over all 64
// processes then sets every process to state other before the first item is taken.
module multilevel_feedback_queue_scheduler_core import mlfq_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             in_item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            out_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [TBL_W-1:0]     cfg_data
);
    logic cmd_valid, cmd_take;
    cmd_t cmd;

    mlfq_front u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .cmd_valid, .cmd, .cmd_take
    );

    mlfq_engine u_engine (
        .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
        .cfg_we, .cfg_idx, .cfg_data,
        .pop, .empty, .out_item
    );
endmodule
